// File: src/cct_pkg.sv
`default_nettype none

package cct_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int DIGIT_IDX_W = $clog2(DIGIT_COUNT);
   localparam int TENS_POS = 2;

   localparam logic [3:0] LIMIT_TENS = 4'd6;
   localparam logic [3:0] LIMIT_DECIMAL = 4'd10;

   localparam logic [7:0] BEEP_SECONDS_RESET = 8'd10;

   localparam logic [1:0] MODE_CODE_CLOCK = 2'd0;
   localparam logic [1:0] MODE_CODE_SETTING = 2'd1;
   localparam logic [1:0] MODE_CODE_COUNTING = 2'd2;
   localparam logic [1:0] MODE_CODE_BEEPING = 2'd3;

   typedef logic [3:0] digit_type;
   typedef digit_type [DIGIT_COUNT-1:0] digits_type;

   typedef enum logic [3:0] {
      RUN_CLOCK = 4'b0001,
      RUN_SETTING = 4'b0010,
      RUN_COUNTING = 4'b0100,
      RUN_BEEPING = 4'b1000
   } run_mode_type;

   typedef struct packed {
      run_mode_type mode;
      digits_type clock_digits;
      digits_type timer_digits;
      logic buzzer;
   } view_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] seg_first;
      logic [7:0] seg_second;
      logic [7:0] seg_third;
      logic [7:0] seg_fourth;
      logic colon_on;
      logic display_blank;
      logic buzzer_on;
   } result_type;

   localparam digits_type CLOCK_RESET = {4'd9, 4'd0, 4'd2, 4'd1};

   function automatic digit_type digit_limit(int p);
      return (p == TENS_POS) ? LIMIT_TENS : LIMIT_DECIMAL;
   endfunction

   function automatic digits_type count_up(digits_type d);
      digits_type r;
      logic carry;
      logic [4:0] v;
      r = d;
      carry = 1'b1;
      for (int p = DIGIT_COUNT - 1; p >= 0; p--) begin
         v = {1'b0, d[DIGIT_IDX_W'(p)]} + {4'b0000, carry};
         if (v >= {1'b0, digit_limit(p)}) begin
            r[DIGIT_IDX_W'(p)] = '0;
            carry = 1'b1;
         end else begin
            r[DIGIT_IDX_W'(p)] = v[3:0];
            carry = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic digits_type count_down(digits_type d);
      digits_type r;
      logic borrow;
      digit_type v;
      r = d;
      borrow = 1'b1;
      for (int p = DIGIT_COUNT - 1; p >= 0; p--) begin
         v = d[DIGIT_IDX_W'(p)];
         if (v < {3'b000, borrow}) begin
            r[DIGIT_IDX_W'(p)] = digit_limit(p) - 4'd1;
            borrow = 1'b1;
         end else begin
            r[DIGIT_IDX_W'(p)] = v - {3'b000, borrow};
            borrow = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] seg_pattern(digit_type d);
      logic [7:0] s;
      case (d)
         4'h0: s = 8'hFC;
         4'h1: s = 8'h60;
         4'h2: s = 8'hDA;
         4'h3: s = 8'hF2;
         4'h4: s = 8'h66;
         4'h5: s = 8'hB6;
         4'h6: s = 8'hBE;
         4'h7: s = 8'hE0;
         4'h8: s = 8'hFE;
         4'h9: s = 8'hE6;
         4'hA: s = 8'hEE;
         4'hB: s = 8'h3E;
         4'hC: s = 8'h9C;
         4'hD: s = 8'h7A;
         4'hE: s = 8'h9E;
         default: s = 8'h8E;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// File: src/clock_and_countdown_timer_unit.sv
// clock and countdown timer unit
// req channel: one beat per time step carrying the minute, second and
// half-second tick flags and the set and plus button levels. a beat is taken
// when req_valid is high and req_stall is low.
// rsp channel: one beat per request beat with the mode, the four segment
// patterns, colon, blank and buzzer levels as they stand after that step.
// the step's state update and display decode run in the cycle the request
// beat is taken and land in the response register.
// throughput is one beat per cycle; the response register is the only
// buffer, so a new request is taken while the held response leaves or when
// it is empty.
// when the receiver stalls with a response held, req_stall goes high and the
// held response stays unchanged until taken.
// csr_write_enable loads beep_seconds from csr_write_data at once; write
// only while idle.
// reset (synchronous) sets the clock to 12:09, clears the timer, selects
// clock display and loads beep_seconds with 10; no response is pending.
`default_nettype none

module clock_and_countdown_timer_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic       req_minute_tick,
   input  wire logic       req_second_tick,
   input  wire logic       req_half_second_tick,
   input  wire logic       req_set_pressed,
   input  wire logic       req_plus_pressed,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [1:0] rsp_mode,
   output      logic [7:0] rsp_seg_first,
   output      logic [7:0] rsp_seg_second,
   output      logic [7:0] rsp_seg_third,
   output      logic [7:0] rsp_seg_fourth,
   output      logic       rsp_colon_on,
   output      logic       rsp_display_blank,
   output      logic       rsp_buzzer_on,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data
);

   cct_pkg::view_type   view;
   cct_pkg::result_type result;
   cct_pkg::result_type rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   cct_core u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .minute_tick      (req_minute_tick),
      .second_tick      (req_second_tick),
      .half_second_tick (req_half_second_tick),
      .set_pressed      (req_set_pressed),
      .plus_pressed     (req_plus_pressed),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .view             (view)
   );

   cct_disp u_disp (
      .view   (view),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode          = rsp_ff.mode;
   assign rsp_seg_first     = rsp_ff.seg_first;
   assign rsp_seg_second    = rsp_ff.seg_second;
   assign rsp_seg_third     = rsp_ff.seg_third;
   assign rsp_seg_fourth    = rsp_ff.seg_fourth;
   assign rsp_colon_on      = rsp_ff.colon_on;
   assign rsp_display_blank = rsp_ff.display_blank;
   assign rsp_buzzer_on     = rsp_ff.buzzer_on;

   // every taken request beat yields a response beat next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("response missing after request beat");

   // blank display exactly in beeping mode
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode == cct_pkg::MODE_CODE_BEEPING) |->
         (rsp_display_blank && !rsp_colon_on && rsp_seg_first == 8'h00 &&
          rsp_seg_second == 8'h00 && rsp_seg_third == 8'h00 && rsp_seg_fourth == 8'h00))
      else $error("beeping response not blank");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode != cct_pkg::MODE_CODE_BEEPING) |->
         (!rsp_display_blank && rsp_colon_on))
      else $error("display blank outside beeping");

   // buzzer only sounds while beeping
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_buzzer_on) |-> (rsp_mode == cct_pkg::MODE_CODE_BEEPING))
      else $error("buzzer on outside beeping");

endmodule

`default_nettype wire

// File: src/cct_core.sv
`default_nettype none

module cct_core (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic           minute_tick,
   input  wire logic           second_tick,
   input  wire logic           half_second_tick,
   input  wire logic           set_pressed,
   input  wire logic           plus_pressed,
   input  wire logic           csr_write_enable,
   input  wire logic [7:0]     csr_write_data,
   output cct_pkg::view_type   view
);

   cct_pkg::digits_type   clock_ff, clock_in;
   cct_pkg::digits_type   timer_ff, timer_in;
   cct_pkg::digits_type   timer_dn;
   cct_pkg::run_mode_type mode_ff, mode_in;
   logic [8:0]            halves_ff, halves_in;
   logic [8:0]            halves_dec;
   logic [8:0]            halves_start;
   logic                  set_was_ff;
   logic                  buzzer_ff, buzzer_in;
   logic [7:0]            beep_ff;
   logic                  rising;

   assign rising       = set_pressed && !set_was_ff;
   assign timer_dn     = cct_pkg::count_down(timer_ff);
   assign halves_start = {beep_ff, 1'b0};
   assign halves_dec   = (halves_ff != 9'd0) ? (halves_ff - 9'd1) : halves_ff;

   always_comb begin
      clock_in  = minute_tick ? cct_pkg::count_up(clock_ff) : clock_ff;
      timer_in  = timer_ff;
      mode_in   = mode_ff;
      halves_in = halves_ff;
      buzzer_in = buzzer_ff;
      unique case (mode_ff)
         cct_pkg::RUN_CLOCK: begin
            if (rising) begin
               mode_in = cct_pkg::RUN_SETTING;
               if (plus_pressed) timer_in = cct_pkg::count_up(timer_ff);
            end
         end
         cct_pkg::RUN_SETTING: begin
            if (set_pressed) begin
               if (plus_pressed) timer_in = cct_pkg::count_up(timer_ff);
            end else if (timer_ff == '0) begin
               halves_in = halves_start;
               if (beep_ff == 8'd0) begin
                  mode_in   = cct_pkg::RUN_CLOCK;
                  buzzer_in = 1'b0;
               end else begin
                  mode_in   = cct_pkg::RUN_BEEPING;
                  buzzer_in = 1'b1;
               end
            end else begin
               mode_in = cct_pkg::RUN_COUNTING;
            end
         end
         cct_pkg::RUN_COUNTING: begin
            if (second_tick) begin
               timer_in = timer_dn;
               if (timer_dn == '0) begin
                  halves_in = halves_start;
                  if (beep_ff == 8'd0) begin
                     mode_in   = cct_pkg::RUN_CLOCK;
                     buzzer_in = 1'b0;
                  end else begin
                     mode_in   = cct_pkg::RUN_BEEPING;
                     buzzer_in = 1'b1;
                  end
               end
            end
         end
         cct_pkg::RUN_BEEPING: begin
            if (half_second_tick) begin
               halves_in = halves_dec;
               if (halves_dec == 9'd0) begin
                  mode_in   = cct_pkg::RUN_CLOCK;
                  buzzer_in = 1'b0;
               end else begin
                  buzzer_in = !buzzer_ff;
               end
            end
         end
         default: begin
            mode_in   = cct_pkg::RUN_CLOCK;
            buzzer_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff   <= cct_pkg::CLOCK_RESET;
         timer_ff   <= '0;
         mode_ff    <= cct_pkg::RUN_CLOCK;
         halves_ff  <= '0;
         set_was_ff <= 1'b0;
         buzzer_ff  <= 1'b0;
      end else if (accept) begin
         clock_ff   <= clock_in;
         timer_ff   <= timer_in;
         mode_ff    <= mode_in;
         halves_ff  <= halves_in;
         set_was_ff <= set_pressed;
         buzzer_ff  <= buzzer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beep_ff <= cct_pkg::BEEP_SECONDS_RESET;
      end else if (csr_write_enable) begin
         beep_ff <= csr_write_data;
      end
   end

   assign view.mode         = mode_in;
   assign view.clock_digits = clock_in;
   assign view.timer_digits = timer_in;
   assign view.buzzer       = buzzer_in;

endmodule

`default_nettype wire

// File: src/cct_disp.sv
`default_nettype none

module cct_disp (
   input  wire cct_pkg::view_type view,
   output cct_pkg::result_type    result
);

   cct_pkg::digits_type shown;

   always_comb begin
      shown = (view.mode == cct_pkg::RUN_CLOCK) ? view.clock_digits : view.timer_digits;
      result.buzzer_on = view.buzzer;
      unique case (view.mode)
         cct_pkg::RUN_CLOCK:    result.mode = cct_pkg::MODE_CODE_CLOCK;
         cct_pkg::RUN_SETTING:  result.mode = cct_pkg::MODE_CODE_SETTING;
         cct_pkg::RUN_COUNTING: result.mode = cct_pkg::MODE_CODE_COUNTING;
         cct_pkg::RUN_BEEPING:  result.mode = cct_pkg::MODE_CODE_BEEPING;
         default:               result.mode = cct_pkg::MODE_CODE_CLOCK;
      endcase
      if (view.mode == cct_pkg::RUN_BEEPING) begin
         result.seg_first     = 8'h00;
         result.seg_second    = 8'h00;
         result.seg_third     = 8'h00;
         result.seg_fourth    = 8'h00;
         result.colon_on      = 1'b0;
         result.display_blank = 1'b1;
      end else begin
         result.seg_first     = cct_pkg::seg_pattern(shown[0]);
         result.seg_second    = cct_pkg::seg_pattern(shown[1]);
         result.seg_third     = cct_pkg::seg_pattern(shown[2]);
         result.seg_fourth    = cct_pkg::seg_pattern(shown[3]);
         result.colon_on      = 1'b1;
         result.display_blank = 1'b0;
      end
   end

endmodule

`default_nettype wire
